// ----- hdl/chunked_hash64_top_defines.svh -----
// ---------------------------------------------------------------------------
// chunked_hash64_top_defines
// Assertion macros shared by the chunked hash RTL.
// ---------------------------------------------------------------------------
`ifndef CHUNKED_HASH64_TOP_DEFINES_SVH
`define CHUNKED_HASH64_TOP_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define CH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked implication check, masked while reset is asserted.
`define CH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ch64_pkg.sv -----
// ---------------------------------------------------------------------------
// ch64_pkg
// Types, constants and helper functions of the chunked 64-bit hash.
// ---------------------------------------------------------------------------
package ch64_pkg;

  localparam int unsigned LEN_W = 32;
  localparam int unsigned IDX_W = LEN_W - 3;

  localparam logic [63:0] K_GOLD  = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] K_MUL_A = 64'hc6a4a7935bd1e995;
  localparam logic [63:0] K_MUL_B = 64'h94d049bb133111eb;
  localparam logic [63:0] K_MUL_C = 64'h2545f4914f6cdd1d;

  localparam int unsigned ROT_A  = 47;
  localparam int unsigned ROT_B1 = 23;
  localparam int unsigned ROT_B2 = 11;
  localparam int unsigned ROT_C  = 33;

  typedef enum logic [1:0] {
    MIX_A,
    MIX_B,
    MIX_C
  } mix_phase_e;

  typedef enum logic [2:0] {
    MS_LEN,
    MS_CHUNK,
    MS_TOTAL,
    MS_TAIL,
    MS_FINAL
  } mix_src_e;

  typedef enum logic [3:0] {
    S_FIRST,
    S_INIT,
    S_INIT_W,
    S_CHK,
    S_CHUNK_MIX,
    S_CHUNK_W,
    S_NEXT,
    S_TOT_W,
    S_TAIL_MIX,
    S_TAIL_W,
    S_FIN,
    S_FIN_W
  } ctl_state_e;

  typedef struct packed {
    logic     load_first;
    logic     load_word;
    logic     mix_start;
    mix_src_e mix_src;
    logic     acc_from_mix;
    logic     acc_clear;
    logic     chunk_step;
    logic     tot_from_mix;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic left_nz;
    logic mix_busy;
    logic out_free;
  } sts_t;

  function automatic logic [63:0] ror64(input logic [63:0] x, input int unsigned r);
    return (x >> r) | (x << (64 - r));
  endfunction

  function automatic logic [63:0] tail_mask(input logic [2:0] rem);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (3'(i) < rem) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  function automatic logic [63:0] mix_const(input mix_phase_e ph);
    logic [63:0] k;
    unique case (ph)
      MIX_A:   k = K_MUL_A;
      MIX_B:   k = K_MUL_B;
      MIX_C:   k = K_MUL_C;
      default: k = K_MUL_A;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/chunked_hash64_top.sv -----
// ---------------------------------------------------------------------------
// chunked_hash64_top
// Streaming 64-bit hash of a byte message fed as little-endian 8-byte beats.
// ---------------------------------------------------------------------------
// Each mix runs on the split 32x32 multiplier path (3 multiplies).
// Full chunk beat: 1 mix between accepts; the first beat of a long message adds
// 1 mix. Tail beat: 3 mixes to the output register, plus a clear step when it
// is also the first beat; next beat is taken in the cycle after the load.
// One beat in flight; a stalled result holds only the next tail's last step.
// Reset (rst_ni low, async) returns to awaiting a first beat, output empty.
module chunked_hash64_top
  import ch64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] chunk_word_i,
  input  logic [31:0] msg_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  cmd_t cmd;
  sts_t sts;

  ch64_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ch64_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .chunk_word_i (chunk_word_i),
    .msg_length_i (msg_length_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .hash_value_o (hash_value_o)
  );

endmodule

// ----- hdl/ch64_mix.sv -----
// ---------------------------------------------------------------------------
// ch64_mix
// Multi-cycle 64-bit mixer: three constant multiplies, each split into
// 32x32 partial products and a summing step with the xor/rotate work.
// ---------------------------------------------------------------------------
module ch64_mix
  import ch64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] operand_i,
  output logic        busy_o,
  output logic [63:0] result_o
);

`include "chunked_hash64_top_defines.svh"

  logic        busy_q, busy_d;
  logic        sum_q, sum_d;
  mix_phase_e  phase_q, phase_d;
  logic [63:0] x_q, x_d;
  logic [63:0] h0_q, h0_d;
  logic [63:0] pp_lo_q, pp_lo_d;
  logic [31:0] pp_x_q, pp_x_d;
  logic [63:0] res_q, res_d;
  logic [63:0] k;
  logic [63:0] prod;
  logic [63:0] pa;
  logic [63:0] pb;
  logic [63:0] cross_a;
  logic [63:0] cross_b;

  always_comb begin
    k       = mix_const(phase_q);
    cross_a = x_q[31:0] * k[63:32];
    cross_b = x_q[63:32] * k[31:0];
    prod    = pp_lo_q + {pp_x_q, 32'h0};
    pa      = prod ^ ror64(prod, ROT_A);
    pb      = prod ^ ror64(prod, ROT_B1);

    busy_d  = busy_q;
    sum_d   = sum_q;
    phase_d = phase_q;
    x_d     = x_q;
    h0_d    = h0_q;
    pp_lo_d = pp_lo_q;
    pp_x_d  = pp_x_q;
    res_d   = res_q;

    if (start_i) begin
      busy_d  = 1'b1;
      sum_d   = 1'b0;
      phase_d = MIX_A;
      x_d     = operand_i;
      h0_d    = operand_i ^ K_GOLD;
    end else if (busy_q && !sum_q) begin
      pp_lo_d = x_q[31:0] * k[31:0];
      pp_x_d  = cross_a[31:0] + cross_b[31:0];
      sum_d   = 1'b1;
    end else if (busy_q) begin
      sum_d = 1'b0;
      unique case (phase_q)
        MIX_A: begin
          x_d     = h0_q ^ pa;
          phase_d = MIX_B;
        end
        MIX_B: begin
          x_d     = ror64(pb, ROT_B2);
          phase_d = MIX_C;
        end
        MIX_C: begin
          res_d  = prod ^ ror64(prod, ROT_C);
          busy_d = 1'b0;
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      sum_q   <= 1'b0;
      phase_q <= MIX_A;
    end else begin
      busy_q  <= busy_d;
      sum_q   <= sum_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    h0_q    <= h0_d;
    pp_lo_q <= pp_lo_d;
    pp_x_q  <= pp_x_d;
    res_q   <= res_d;
  end

  assign busy_o   = busy_q;
  assign result_o = res_q;

  `CH_ASSERT_IMP(a_mix_last_step_done, busy_q && sum_q && phase_q == MIX_C && !start_i, ##1 !busy_q, "mixer still busy after last step")

endmodule

// ----- hdl/ch64_ctrl.sv -----
// ---------------------------------------------------------------------------
// ch64_ctrl
// Sequencer for the chunked hash: per-message init, one mix per full
// chunk, three mixes for the tail and the output hand-off.
// ---------------------------------------------------------------------------
module ch64_ctrl
  import ch64_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

`include "chunked_hash64_top_defines.svh"

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_FIRST;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.mix_src = MS_LEN;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_FIRST: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_first = 1'b1;
          state_d          = S_INIT;
        end
      end
      S_INIT: begin
        if (sts_i.left_nz) begin
          cmd_o.mix_start = 1'b1;
          cmd_o.mix_src   = MS_LEN;
          state_d         = S_INIT_W;
        end else begin
          cmd_o.acc_clear = 1'b1;
          state_d         = S_CHK;
        end
      end
      S_INIT_W: begin
        if (!sts_i.mix_busy) begin
          cmd_o.acc_from_mix = 1'b1;
          state_d            = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.left_nz) begin
          cmd_o.chunk_step = 1'b1;
          state_d          = S_CHUNK_MIX;
        end else begin
          cmd_o.mix_start = 1'b1;
          cmd_o.mix_src   = MS_TOTAL;
          state_d         = S_TOT_W;
        end
      end
      S_CHUNK_MIX: begin
        cmd_o.mix_start = 1'b1;
        cmd_o.mix_src   = MS_CHUNK;
        state_d         = S_CHUNK_W;
      end
      S_CHUNK_W: begin
        if (!sts_i.mix_busy) begin
          cmd_o.acc_from_mix = 1'b1;
          state_d            = S_NEXT;
        end
      end
      S_NEXT: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_word = 1'b1;
          state_d         = S_CHK;
        end
      end
      S_TOT_W: begin
        if (!sts_i.mix_busy) begin
          cmd_o.tot_from_mix = 1'b1;
          state_d            = S_TAIL_MIX;
        end
      end
      S_TAIL_MIX: begin
        cmd_o.mix_start = 1'b1;
        cmd_o.mix_src   = MS_TAIL;
        state_d         = S_TAIL_W;
      end
      S_TAIL_W: begin
        if (!sts_i.mix_busy) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.mix_start = 1'b1;
        cmd_o.mix_src   = MS_FINAL;
        state_d         = S_FIN_W;
      end
      S_FIN_W: begin
        if (!sts_i.mix_busy && sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_FIRST;
        end
      end
      default: begin
        state_d = S_FIRST;
      end
    endcase
  end

  `CH_ASSERT_IMP(a_ctrl_no_restart, cmd_o.mix_start, !sts_i.mix_busy, "mix started while busy")
  `CH_ASSERT_IMP(a_ctrl_out_free, cmd_o.out_load, sts_i.out_free, "output loaded over pending beat")

endmodule

// ----- hdl/ch64_dp.sv -----
// ---------------------------------------------------------------------------
// ch64_dp
// Datapath of the chunked hash: length and chunk counters, accumulator,
// mixer operand select and the output register.
// ---------------------------------------------------------------------------
module ch64_dp
  import ch64_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [63:0] chunk_word_i,
  input  logic [31:0] msg_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

`include "chunked_hash64_top_defines.svh"

  logic [63:0]      word_q;
  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] len_in;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] left_q;
  logic [63:0]      kg_q;
  logic [63:0]      acc_q;
  logic [63:0]      tot_q;
  logic [63:0]      hash_q;
  logic             out_valid_q, out_valid_d;
  logic [63:0]      mix_operand;
  logic             mix_busy;
  logic [63:0]      mix_result;

  assign len_in = LEN_W'(msg_length_i);

  always_comb begin
    unique case (cmd_i.mix_src)
      MS_LEN:   mix_operand = 64'(len_q) ^ K_GOLD;
      MS_CHUNK: mix_operand = acc_q ^ word_q ^ kg_q;
      MS_TOTAL: mix_operand = 64'(idx_q) + 64'(len_q);
      MS_TAIL:  mix_operand = acc_q ^ (word_q & tail_mask(len_q[2:0])) ^ tot_q;
      MS_FINAL: mix_operand = mix_result;
      default:  mix_operand = mix_result;
    endcase
  end

  ch64_mix u_mix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mix_start),
    .operand_i (mix_operand),
    .busy_o    (mix_busy),
    .result_o  (mix_result)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_first) begin
      word_q <= chunk_word_i;
      len_q  <= len_in;
      idx_q  <= '0;
      left_q <= IDX_W'(len_in >> 3);
      kg_q   <= '0;
    end else if (cmd_i.load_word) begin
      word_q <= chunk_word_i;
    end
    if (cmd_i.chunk_step) begin
      idx_q  <= idx_q + 1'b1;
      left_q <= left_q - 1'b1;
      kg_q   <= kg_q + K_GOLD;
    end
    if (cmd_i.acc_clear) begin
      acc_q <= '0;
    end else if (cmd_i.acc_from_mix) begin
      acc_q <= mix_result;
    end
    if (cmd_i.tot_from_mix) begin
      tot_q <= mix_result;
    end
    if (cmd_i.out_load) begin
      hash_q <= mix_result;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.left_nz  = (left_q != '0);
  assign sts_o.mix_busy = mix_busy;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

  `CH_ASSERT_IMP(a_dp_no_underflow, cmd_i.chunk_step, left_q != '0, "chunk step with no chunks left")

endmodule
